// ----- sv/byte_ring_fifo_contiguous_area_assert.svh -----
// Assertion macros used by the checker of the byte ring buffer.
`ifndef BYTE_RING_FIFO_CONTIGUOUS_AREA_ASSERT_SVH
`define BYTE_RING_FIFO_CONTIGUOUS_AREA_ASSERT_SVH

// Same-cycle implication, switched off while reset is asserted.
`define BRFCA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("brfca assertion failed");

// Next-cycle implication, switched off while reset is asserted.
`define BRFCA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("brfca assertion failed");

// Next-cycle implication that is also checked during reset.
`define BRFCA_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("brfca assertion failed");

`endif

// ----- sv/brfca_pkg.sv -----
`default_nettype none

package brfca_pkg;

    localparam logic [1:0] OP_QUERY  = 2'd0;
    localparam logic [1:0] OP_STORE  = 2'd1;
    localparam logic [1:0] OP_COMMIT = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_FULL_EMPTY = 2'd1;
    localparam logic [1:0] ST_OVERFLOW   = 2'd2;

    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = 2;
    localparam int OQ_LW    = 3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [11:0] offset;
        logic [7:0]  data_byte;
        logic [12:0] length;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  read_byte;
        logic        byte_valid;
        logic        last;
        logic [11:0] area_start;
        logic [12:0] area_length;
        logic [6:0]  read_count;
        logic [12:0] fill_level;
        logic [1:0]  status;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  operation;
        logic [11:0] offset;
        logic [7:0]  data_byte;
        logic [12:0] length;
        logic [6:0]  read_max;
    } t_cmd;

endpackage

`default_nettype wire

// ----- sv/byte_ring_fifo_contiguous_area.sv -----
// Byte ring buffer with a contiguous write area. Each input item is a query of the free
// area, a byte store at an offset inside that area, a commit of a length, or a read of up
// to MAX_READ bytes; the first three give one result each, a read gives one result per
// popped byte (or a single empty result). Items enter a two-entry command queue and are
// executed by a back end that owns the store and the read position and fill level;
// results leave through a four-entry result queue. A read pops one byte per cycle while
// the result queue has room, limited by the single read port of the byte store; each
// result is registered in the back end before it enters the result queue. A capacity
// write empties the buffer and must only be issued while no item or result is in flight.
// Store contents are undefined until written.
`default_nettype none

module byte_ring_fifo_contiguous_area #(
    parameter int STORE_DEPTH = 4096,
    parameter int MAX_READ    = 64
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        push,
    output logic                       full,
    input  wire  brfca_pkg::t_in_item  i_item,
    output logic                       empty,
    input  wire                        pop,
    output brfca_pkg::t_out_item       o_result,
    input  wire                        i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire  [12:0]                i_cfg_data
);

    logic                              cmd_valid;
    brfca_pkg::t_cmd                   cmd;
    logic                              cmd_pop;
    logic [brfca_pkg::OQ_LW-1:0]       out_level;
    logic                              res_valid;
    brfca_pkg::t_out_item              res;

    assign o_cfg_ready = 1'b1;

    brfca_front #(
        .MAX_READ (MAX_READ)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_item      (i_item),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    brfca_back #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_out_level (out_level),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    brfca_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_level     (out_level),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire

// ----- sv/brfca_front.sv -----
`default_nettype none

module brfca_front #(
    parameter int MAX_READ = 64
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_push,
    output logic                       o_full,
    input  wire  brfca_pkg::t_in_item  i_item,
    output logic                       o_cmd_valid,
    output brfca_pkg::t_cmd            o_cmd,
    input  wire                        i_cmd_pop
);

    brfca_pkg::t_cmd r_q [2];
    logic            r_wr;
    logic            r_rd;
    logic [1:0]      r_cnt;
    logic            accept;
    logic            take;
    brfca_pkg::t_cmd cmd;

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];
    assign accept      = i_push && !o_full;
    assign take        = i_cmd_pop && o_cmd_valid;

    always_comb begin
        cmd.operation = i_item.operation;
        cmd.offset    = i_item.offset;
        cmd.data_byte = i_item.data_byte;
        cmd.length    = i_item.length;
        if (i_item.length > 13'(MAX_READ)) begin
            cmd.read_max = 7'(MAX_READ);
        end else begin
            cmd.read_max = i_item.length[6:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (accept) begin
                r_q[r_wr] <= cmd;
                r_wr      <= ~r_wr;
            end
            if (take) begin
                r_rd <= ~r_rd;
            end
            unique case ({accept, take})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- sv/brfca_back.sv -----
`default_nettype none

module brfca_back #(
    parameter int STORE_DEPTH = 4096
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_valid,
    input  wire  [12:0]                  i_cfg_data,
    input  wire                          i_cmd_valid,
    input  wire  brfca_pkg::t_cmd        i_cmd,
    output logic                         o_cmd_pop,
    input  wire  [brfca_pkg::OQ_LW-1:0]  i_out_level,
    output logic                         o_res_valid,
    output brfca_pkg::t_out_item         o_res
);

    localparam int          AW        = $clog2(STORE_DEPTH);
    localparam logic [16:0] DEPTH17   = 17'(STORE_DEPTH);
    localparam logic [12:0] CAP_RESET = (STORE_DEPTH < 4096) ? 13'(STORE_DEPTH) : 13'd4096;
    localparam int          OQ_LW     = brfca_pkg::OQ_LW;

    typedef struct packed {
        logic [12:0] start;
        logic [12:0] len;
    } t_area;

    function automatic t_area free_area(input logic [12:0] rd, input logic [12:0] fill,
                                        input logic [12:0] cap);
        logic [13:0] wr;
        logic [12:0] top;
        t_area       a;
        wr  = {1'b0, rd} + {1'b0, fill};
        top = cap;
        if (wr >= {1'b0, cap}) begin
            wr  = wr - {1'b0, cap};
            top = rd;
        end
        a.start = wr[12:0];
        a.len   = (top > wr[12:0]) ? (top - wr[12:0]) : 13'd0;
        return a;
    endfunction

    logic [7:0]           r_mem [STORE_DEPTH];
    logic [7:0]           r_rdata;
    logic [12:0]          r_cap;
    logic [12:0]          r_rd_pos;
    logic [12:0]          r_fill;
    logic                 r_busy;
    logic [6:0]           r_rem;
    logic [6:0]           r_cnt;
    logic                 r_pend_v;
    logic                 r_pend_byte;
    brfca_pkg::t_out_item r_pend;

    logic [12:0]          n_rd_pos;
    logic [12:0]          n_fill;
    logic                 n_busy;
    logic [6:0]           n_rem;
    logic [6:0]           n_cnt;
    logic                 n_pend_byte;
    brfca_pkg::t_out_item n_pend;

    logic                 step;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;
    t_area                area_now;
    t_area                area_new;
    logic [6:0]           rem;
    logic [6:0]           cnt;
    logic [12:0]          pos_inc;
    logic [12:0]          room;
    logic [13:0]          store_addr;
    logic [12:0]          cap_clamped;

    assign step     = i_cmd_valid
                      && (OQ_LW'(i_out_level + OQ_LW'(r_pend_v)) < OQ_LW'(brfca_pkg::OQ_DEPTH));
    assign area_now = free_area(r_rd_pos, r_fill, r_cap);
    assign rem      = r_busy ? r_rem
                             : (({6'd0, i_cmd.read_max} > r_fill) ? r_fill[6:0] : i_cmd.read_max);
    assign cnt      = (r_busy ? r_cnt : 7'd0) + 7'd1;
    assign pos_inc  = r_rd_pos + 13'd1;
    assign room     = r_cap - r_fill;
    assign store_addr = {1'b0, area_now.start} + {2'b00, i_cmd.offset};

    always_comb begin
        if (i_cfg_data == 13'd0) begin
            cap_clamped = 13'd1;
        end else if ({4'd0, i_cfg_data} > DEPTH17) begin
            cap_clamped = 13'(STORE_DEPTH);
        end else begin
            cap_clamped = i_cfg_data;
        end
    end

    always_comb begin
        n_rd_pos    = r_rd_pos;
        n_fill      = r_fill;
        n_busy      = r_busy;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_pend      = '0;
        n_pend_byte = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = AW'(store_addr);
        mem_re      = 1'b0;
        mem_raddr   = AW'(r_rd_pos);
        o_cmd_pop   = 1'b0;
        area_new    = free_area(r_rd_pos, r_fill + i_cmd.length, r_cap);
        if (step) begin
            n_pend.last       = 1'b1;
            n_pend.fill_level = r_fill;
            n_pend.status     = brfca_pkg::ST_OK;
            unique case (i_cmd.operation)
                brfca_pkg::OP_QUERY: begin
                    o_cmd_pop          = 1'b1;
                    n_pend.area_start  = area_now.start[11:0];
                    n_pend.area_length = area_now.len;
                    if (area_now.len == 13'd0) begin
                        n_pend.status = brfca_pkg::ST_FULL_EMPTY;
                    end
                end
                brfca_pkg::OP_STORE: begin
                    o_cmd_pop          = 1'b1;
                    n_pend.area_start  = area_now.start[11:0];
                    n_pend.area_length = area_now.len;
                    if ({1'b0, i_cmd.offset} < area_now.len) begin
                        mem_we = 1'b1;
                    end else begin
                        n_pend.status = brfca_pkg::ST_OVERFLOW;
                    end
                end
                brfca_pkg::OP_COMMIT: begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.length > room) begin
                        n_fill             = r_cap;
                        n_pend.status      = brfca_pkg::ST_OVERFLOW;
                        area_new           = free_area(r_rd_pos, r_cap, r_cap);
                    end else begin
                        n_fill = r_fill + i_cmd.length;
                    end
                    n_pend.fill_level  = n_fill;
                    n_pend.area_start  = area_new.start[11:0];
                    n_pend.area_length = area_new.len;
                end
                brfca_pkg::OP_READ: begin
                    if (rem == 7'd0) begin
                        o_cmd_pop = 1'b1;
                        if (r_fill == 13'd0) begin
                            n_pend.status = brfca_pkg::ST_FULL_EMPTY;
                        end
                    end else begin
                        mem_re            = 1'b1;
                        n_pend_byte       = 1'b1;
                        n_pend.byte_valid = 1'b1;
                        n_pend.read_count = cnt;
                        n_pend.last       = (rem == 7'd1);
                        n_fill            = r_fill - 13'd1;
                        n_pend.fill_level = n_fill;
                        n_rd_pos          = (pos_inc >= r_cap) ? 13'd0 : pos_inc;
                        if (rem == 7'd1) begin
                            o_cmd_pop = 1'b1;
                            n_busy    = 1'b0;
                        end else begin
                            n_busy = 1'b1;
                            n_rem  = rem - 7'd1;
                            n_cnt  = cnt;
                        end
                    end
                end
                default: begin
                    o_cmd_pop = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= i_cmd.data_byte;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap    <= CAP_RESET;
            r_rd_pos <= 13'd0;
            r_fill   <= 13'd0;
            r_busy   <= 1'b0;
            r_rem    <= 7'd0;
            r_cnt    <= 7'd0;
            r_pend_v <= 1'b0;
        end else if (i_cfg_valid) begin
            r_cap    <= cap_clamped;
            r_rd_pos <= 13'd0;
            r_fill   <= 13'd0;
            r_busy   <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            r_rd_pos <= n_rd_pos;
            r_fill   <= n_fill;
            r_busy   <= n_busy;
            r_rem    <= n_rem;
            r_cnt    <= n_cnt;
            r_pend_v <= step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend      <= n_pend;
        r_pend_byte <= n_pend_byte;
    end

    always_comb begin
        o_res = r_pend;
        if (r_pend_byte) begin
            o_res.read_byte = r_rdata;
        end
    end

    assign o_res_valid = r_pend_v;

endmodule

`default_nettype wire

// ----- sv/brfca_outq.sv -----
`default_nettype none

module brfca_outq (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_res_valid,
    input  wire  brfca_pkg::t_out_item   i_res,
    output logic [brfca_pkg::OQ_LW-1:0]  o_level,
    output logic                         o_empty,
    input  wire                          i_pop,
    output brfca_pkg::t_out_item         o_result
);

    brfca_pkg::t_out_item             r_q [brfca_pkg::OQ_DEPTH];
    logic [brfca_pkg::OQ_AW-1:0]      r_wr;
    logic [brfca_pkg::OQ_AW-1:0]      r_rd;
    logic [brfca_pkg::OQ_LW-1:0]      r_cnt;
    logic                             take;

    assign o_level  = r_cnt;
    assign o_empty  = (r_cnt == '0);
    assign o_result = r_q[r_rd];
    assign take     = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_res_valid) begin
                r_q[r_wr] <= i_res;
                r_wr      <= r_wr + 1'b1;
            end
            if (take) begin
                r_rd <= r_rd + 1'b1;
            end
            unique case ({i_res_valid, take})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- sv/brfca_checker.sv -----
`default_nettype none
`include "byte_ring_fifo_contiguous_area_assert.svh"

module brfca_checker (
    input wire                        i_clk,
    input wire                        i_rst_n,
    input wire                        i_full,
    input wire                        i_empty,
    input wire                        i_pop,
    input wire brfca_pkg::t_out_item  i_result
);

    `BRFCA_ASSERT_NEXT_ALWAYS(a_reset_clears, i_clk, !i_rst_n, i_empty && !i_full)

    `BRFCA_ASSERT_NEXT(a_result_holds, i_clk, i_rst_n, !i_empty && !i_pop,
        !i_empty && $stable(i_result))

    `BRFCA_ASSERT_IMPL(a_read_sequence, i_clk, i_rst_n,
        $past(i_rst_n)
        && $past(i_pop && !i_empty && i_result.byte_valid && !i_result.last) && !i_empty,
        i_result.byte_valid
        && (i_result.read_count == 7'($past(i_result.read_count) + 7'd1))
        && (i_result.fill_level == 13'($past(i_result.fill_level) - 13'd1)))

endmodule

bind byte_ring_fifo_contiguous_area brfca_checker u_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_full   (full),
    .i_empty  (empty),
    .i_pop    (pop),
    .i_result (o_result)
);

`default_nettype wire
